// ----- src/lcd_nw_pkg.sv -----
// lcd_nw_pkg: shared types and constants for the character-lcd nibble writer
// no dependencies; imported by lcd_nw_dec, lcd_nw_ser and char_lcd_nibble_writer
`default_nettype none

package lcd_nw_pkg;

    // request codes carried in tuser
    localparam logic [1:0] CMD_CHAR  = 2'd0;
    localparam logic [1:0] CMD_RAW   = 2'd1;
    localparam logic [1:0] CMD_GOTO  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // controller command bytes
    localparam logic [7:0] DDRAM_SET = 8'h80;
    localparam logic [7:0] CLEAR_CMD = 8'h01;

    // geometry
    localparam logic [4:0] WIDTH_2X16   = 5'd16;
    localparam logic [4:0] WIDTH_4X20   = 5'd20;
    localparam logic [6:0] TOTAL_2X16   = 7'd32;
    localparam logic [6:0] TOTAL_4X20   = 7'd80;

    // one or two bytes waiting to go out as nibbles
    typedef struct packed {
        logic       rs;     // register select of the first byte
        logic [7:0] b0;     // first byte
        logic       two;    // second byte (always a command) follows
        logic [7:0] b1;     // second byte
    } t_pkt;

    // ddram offset of each line
    function automatic logic [6:0] line_offset(input logic [1:0] row);
        logic [6:0] off;
        case (row)
            2'd0:    off = 7'd0;
            2'd1:    off = 7'd64;
            2'd2:    off = 7'd20;
            default: off = 7'd84;
        endcase
        return off;
    endfunction

    // linear cursor position of column 0 of a line
    function automatic logic [6:0] line_base(input logic geo, input logic [1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'd0;
            2'd1:    base = geo ? 7'd20 : 7'd16;
            2'd2:    base = 7'd40;
            default: base = 7'd60;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ----- src/lcd_nw_dec.sv -----
// lcd_nw_dec: turns one request into a byte pair and keeps the cursor position
// depends on lcd_nw_pkg
`default_nettype none

module lcd_nw_dec (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_geo,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_cmd,
    input  wire logic [7:0]       i_value,
    input  wire logic [1:0]       i_row,
    input  wire logic [4:0]       i_column,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output lcd_nw_pkg::t_pkt      o_pkt
);
    import lcd_nw_pkg::*;

    logic       r_valid;
    t_pkt       r_pkt;
    logic [6:0] r_cursor;
    t_pkt       n_pkt;
    logic [6:0] n_cursor;

    logic [4:0] wm1;
    logic [6:0] total;
    logic [6:0] pos;
    logic       wrap;
    logic       eol;
    logic [1:0] next_row;
    logic [1:0] row_m;
    logic [4:0] col_c;
    logic       take;

    assign take    = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_pkt   = r_pkt;

    // line end and wrap detection for a character write
    always_comb begin
        wm1   = i_geo ? (WIDTH_4X20 - 5'd1) : (WIDTH_2X16 - 5'd1);
        total = i_geo ? TOTAL_4X20 : TOTAL_2X16;
        pos   = r_cursor + 7'd1;
        wrap  = pos >= total;
        if (i_geo) begin
            eol = !wrap && (pos == 7'd20 || pos == 7'd40 || pos == 7'd60);
        end else begin
            eol = !wrap && (pos[3:0] == 4'd0) && (pos != 7'd0);
        end
        if (!i_geo || pos == 7'd20) begin
            next_row = 2'd1;
        end else if (pos == 7'd40) begin
            next_row = 2'd2;
        end else begin
            next_row = 2'd3;
        end
        row_m = i_geo ? i_row : {1'b0, i_row[0]};
        col_c = (i_column > wm1) ? wm1 : i_column;
    end

    // byte pair and new cursor for each request
    always_comb begin
        n_pkt.rs  = 1'b0;
        n_pkt.b0  = i_value;
        n_pkt.two = 1'b0;
        n_pkt.b1  = DDRAM_SET;
        n_cursor  = r_cursor;
        case (i_cmd)
            CMD_CHAR: begin
                n_pkt.rs  = 1'b1;
                n_pkt.two = wrap || eol;
                if (wrap) begin
                    n_pkt.b1 = DDRAM_SET;
                    n_cursor = 7'd0;
                end else begin
                    n_pkt.b1 = DDRAM_SET + {1'b0, line_offset(next_row)};
                    n_cursor = pos;
                end
            end
            CMD_RAW: begin
                n_pkt.b0 = i_value;
            end
            CMD_GOTO: begin
                n_pkt.b0 = DDRAM_SET + {1'b0, line_offset(row_m)} + {3'd0, col_c};
                n_cursor = line_base(i_geo, row_m) + {2'd0, col_c};
            end
            default: begin
                n_pkt.b0 = CLEAR_CMD;
                n_cursor = 7'd0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_cursor <= 7'd0;
        end else begin
            if (take) begin
                r_valid  <= 1'b1;
                r_cursor <= n_cursor;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pkt <= n_pkt;
        end
    end

endmodule

`default_nettype wire

// ----- src/lcd_nw_ser.sv -----
// lcd_nw_ser: sends one or two bytes out as nibbles, high nibble first
// depends on lcd_nw_pkg
`default_nettype none

module lcd_nw_ser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire lcd_nw_pkg::t_pkt i_pkt,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_rs,
    output logic [3:0]            o_nibble,
    output logic                  o_last
);
    import lcd_nw_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_pkt       r_pkt;
    logic       load;

    // nibble select
    always_comb begin
        o_rs   = (r_idx[1] == 1'b0) ? r_pkt.rs : 1'b0;
        o_last = (r_idx == 2'd1 && !r_pkt.two) || (r_idx == 2'd3);
        case (r_idx)
            2'd0:    o_nibble = r_pkt.b0[7:4];
            2'd1:    o_nibble = r_pkt.b0[3:0];
            2'd2:    o_nibble = r_pkt.b1[7:4];
            default: o_nibble = r_pkt.b1[3:0];
        endcase
    end

    assign o_valid = r_valid;
    assign o_ready = !r_valid || (i_ready && o_last);
    assign load    = i_valid && o_ready;

    // nibble counter and valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= 2'd0;
            end else if (r_valid && i_ready) begin
                if (o_last) begin
                    r_valid <= 1'b0;
                end
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pkt <= i_pkt;
        end
    end

endmodule

`default_nettype wire

// ----- src/char_lcd_nibble_writer.sv -----
// char_lcd_nibble_writer: character-lcd request to 4-bit bus transfer converter
// the request is registered in lcd_nw_dec, then in lcd_nw_ser, before its first nibble is offered
//   on m_axis; the serialiser takes the next byte pair with the last nibble of the current one
// throughput: one nibble per cycle from the serialiser while m_axis_tready is high,
//   two nibbles per request, four for a character write that moves to another line
// reset: synchronous active-low; clears the cursor, geometry (2x16) and all valid flags
// depends on lcd_nw_pkg, lcd_nw_dec, lcd_nw_ser
`default_nettype none

module char_lcd_nibble_writer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: geometry_mode
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // value[7:0], row[9:8], column[14:10], zero
    input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // nibble stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // nibble[3:0], zero
    output logic [0:0]       m_axis_tuser,  // reg_select[0]
    output logic             m_axis_tlast
);
    import lcd_nw_pkg::*;

    logic r_geo;
    logic dec_valid;
    logic ser_ready;
    t_pkt dec_pkt;
    logic ser_rs;
    logic [3:0] ser_nibble;

    // geometry register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geo <= 1'b0;
        end else if (i_cfg_valid) begin
            r_geo <= i_cfg_data;
        end
    end

    lcd_nw_dec u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geo    (r_geo),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cmd    (s_axis_tuser),
        .i_value  (s_axis_tdata[7:0]),
        .i_row    (s_axis_tdata[9:8]),
        .i_column (s_axis_tdata[14:10]),
        .o_valid  (dec_valid),
        .i_ready  (ser_ready),
        .o_pkt    (dec_pkt)
    );

    lcd_nw_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dec_valid),
        .o_ready  (ser_ready),
        .i_pkt    (dec_pkt),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_rs     (ser_rs),
        .o_nibble (ser_nibble),
        .o_last   (m_axis_tlast)
    );

    // output packing
    assign m_axis_tdata = {4'd0, ser_nibble};
    assign m_axis_tuser = ser_rs;

endmodule

`default_nettype wire

// ----- verif/tb_char_lcd_nibble_writer.sv -----
// tb_char_lcd_nibble_writer: self-checking testbench for the character-lcd nibble writer
// drives request transfers, predicts every nibble transfer with its own cursor model
// depends on lcd_nw_pkg and char_lcd_nibble_writer

module tb_char_lcd_nibble_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd_nw_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    // one request as the sender sees it
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] value;
        logic [1:0] row;
        logic [4:0] column;
    } t_lcd_req;

    // one nibble transfer on the bus
    typedef struct {
        logic       rs;
        logic [3:0] nib;
        logic       fin;
    } t_lcd_nibble;

    // ddram address of column 0 of each line
    localparam logic [7:0] LINE_ADDR [4] = '{8'd0, 8'd64, 8'd20, 8'd84};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data    = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state
    logic        geo_mode   = 1'b0;
    logic [6:0]  cursor_pos = '0;

    t_lcd_req    req_backlog[$];
    t_lcd_req    req_on_bus;
    t_lcd_nibble nibbles_due[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int err_count     = 0;
    int req_count     = 0;
    int nib_count     = 0;
    int geo_writes    = 0;
    int cycle_count   = 0;

    char_lcd_nibble_writer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_char_lcd_nibble_writer: done, errors");
            $finish;
        end
    end

    // one byte as two nibbles, high nibble first
    function automatic void push_byte(input logic rs, input logic [7:0] b, input logic fin);
        t_lcd_nibble n;
        n.rs  = rs;
        n.nib = b[7:4];
        n.fin = 1'b0;
        nibbles_due.push_back(n);
        n.nib = b[3:0];
        n.fin = fin;
        nibbles_due.push_back(n);
    endfunction

    // set-ddram-address command and cursor update
    function automatic void move_cursor(input logic [1:0] row, input logic [4:0] col);
        logic [4:0] w;
        logic [1:0] r;
        logic [4:0] c;
        logic [7:0] addr;
        w    = geo_mode ? WIDTH_4X20 : WIDTH_2X16;
        r    = geo_mode ? row : {1'b0, row[0]};
        c    = (col > w - 5'd1) ? w - 5'd1 : col;
        addr = DDRAM_SET + LINE_ADDR[r] + {3'b000, c};
        push_byte(1'b0, addr, 1'b1);
        cursor_pos = 7'(int'(r) * int'(w) + int'(c));
    endfunction

    // expected nibbles of one accepted request
    function automatic void predict_request(input t_lcd_req rq);
        int   w;
        int   total;
        int   pos;
        logic wrap;
        logic eol;
        case (rq.cmd)
            CMD_CHAR: begin
                w     = geo_mode ? int'(WIDTH_4X20) : int'(WIDTH_2X16);
                total = geo_mode ? int'(TOTAL_4X20) : int'(TOTAL_2X16);
                pos   = (int'(cursor_pos) + 1) % 128;
                wrap  = pos >= total;
                eol   = !wrap && pos != 0 && (pos % w) == 0;
                push_byte(1'b1, rq.value, !(wrap || eol));
                cursor_pos = 7'(pos);
                if (wrap) begin
                    move_cursor(2'd0, 5'd0);
                end else if (eol) begin
                    move_cursor(2'(pos / w), 5'd0);
                end
            end
            CMD_RAW: begin
                push_byte(1'b0, rq.value, 1'b1);
            end
            CMD_GOTO: begin
                move_cursor(rq.row, rq.column);
            end
            default: begin
                push_byte(1'b0, CLEAR_CMD, 1'b1);
                cursor_pos = '0;
            end
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(req_on_bus);
                req_count <= req_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    req_on_bus = req_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, req_on_bus.column, req_on_bus.row,
                                      req_on_bus.value};
                    s_axis_tuser  <= req_on_bus.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // nibble monitor and checker
    always @(posedge i_clk) begin
        t_lcd_nibble want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                nib_count <= nib_count + 1;
                if (nibbles_due.size() == 0) begin
                    $error("nibble transfer with none expected: rs %0d nibble %h last %0d",
                           m_axis_tuser[0], m_axis_tdata[3:0], m_axis_tlast);
                    err_count = err_count + 1;
                end else begin
                    want = nibbles_due.pop_front();
                    if (m_axis_tuser[0] !== want.rs) begin
                        $error("reg_select: expected %0d, got %0d", want.rs, m_axis_tuser[0]);
                        err_count = err_count + 1;
                    end
                    if (m_axis_tdata[3:0] !== want.nib) begin
                        $error("nibble: expected %h, got %h", want.nib, m_axis_tdata[3:0]);
                        err_count = err_count + 1;
                    end
                    if (m_axis_tlast !== want.fin) begin
                        $error("last: expected %0d, got %0d", want.fin, m_axis_tlast);
                        err_count = err_count + 1;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic queue_request(input logic [1:0] cmd, input logic [7:0] value,
                                 input logic [1:0] row, input logic [4:0] column);
        t_lcd_req rq;
        rq.cmd    = cmd;
        rq.value  = value;
        rq.row    = row;
        rq.column = column;
        req_backlog.push_back(rq);
    endtask

    // wait until every request is in and every nibble is out
    task automatic wait_drained();
        while (req_backlog.size() != 0 || s_axis_tvalid || nibbles_due.size() != 0)
            @(posedge i_clk);
    endtask

    // geometry write, only with the block idle
    task automatic write_geometry(input logic geo);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= geo;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        geo_mode   = geo;
        geo_writes = geo_writes + 1;
    endtask

    // random request, biased towards line ends and character runs
    function automatic t_lcd_req make_request();
        t_lcd_req rq;
        int       roll;
        int       w;
        roll      = $urandom_range(0, 99);
        w         = geo_mode ? int'(WIDTH_4X20) : int'(WIDTH_2X16);
        rq.value  = 8'($urandom);
        rq.row    = 2'($urandom);
        rq.column = 5'($urandom_range(0, 19));
        if (roll < 55) begin
            rq.cmd = CMD_CHAR;
        end else if (roll < 65) begin
            rq.cmd = CMD_RAW;
        end else if (roll < 94) begin
            rq.cmd = CMD_GOTO;
            if ($urandom_range(0, 1) == 1)
                rq.column = 5'(w - 1 - int'($urandom_range(0, 2)));
            else if ($urandom_range(0, 4) == 0)
                rq.column = 5'($urandom_range(20, 31));
        end else begin
            rq.cmd = CMD_CLEAR;
        end
        return rq;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            req_backlog.push_back(make_request());
    endtask

    // main sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct  = 9;
        sink_idle_pct = 80;

        // two lines of 16: byte extremes, raw commands, masking, clamping, wrap, line end
        write_geometry(1'b0);
        queue_request(CMD_CHAR,  8'h00, 2'd0, 5'd0);
        queue_request(CMD_CHAR,  8'hFF, 2'd3, 5'd31);
        queue_request(CMD_RAW,   CLEAR_CMD, 2'd0, 5'd0);
        queue_request(CMD_RAW,   8'hC0, 2'd1, 5'd5);
        queue_request(CMD_RAW,   8'hFF, 2'd0, 5'd0);
        queue_request(CMD_GOTO,  8'hFF, 2'd3, 5'd31);
        queue_request(CMD_CHAR,  8'h41, 2'd0, 5'd0);
        queue_request(CMD_GOTO,  8'h00, 2'd0, 5'd15);
        queue_request(CMD_CHAR,  8'h5A, 2'd0, 5'd0);
        queue_request(CMD_CLEAR, 8'hAA, 2'd2, 5'd17);
        queue_request(CMD_GOTO,  8'h55, 2'd2, 5'd0);

        // four lines of 20: wrap from the last line, line ends, clamping
        write_geometry(1'b1);
        queue_request(CMD_GOTO,  8'h00, 2'd3, 5'd19);
        queue_request(CMD_CHAR,  8'h7E, 2'd0, 5'd0);
        queue_request(CMD_GOTO,  8'h00, 2'd1, 5'd19);
        queue_request(CMD_CHAR,  8'h30, 2'd0, 5'd0);
        queue_request(CMD_GOTO,  8'h00, 2'd2, 5'd31);
        queue_request(CMD_CHAR,  8'h31, 2'd0, 5'd0);
        queue_request(CMD_GOTO,  8'h00, 2'd3, 5'd10);

        // cursor beyond the smaller geometry wraps on the next character
        write_geometry(1'b0);
        queue_request(CMD_CHAR,  8'h80, 2'd0, 5'd0);
        queue_request(CMD_GOTO,  8'h00, 2'd1, 5'd20);
        queue_request(CMD_CLEAR, 8'h00, 2'd0, 5'd0);

        // random phases across both geometries and idling patterns
        write_geometry(1'b1);
        run_random(140);
        write_geometry(1'b0);
        src_idle_pct  = 80;
        sink_idle_pct = 9;
        run_random(140);
        write_geometry(1'b1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(130);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests and %0d nibble transfers over %0d geometry writes",
                 req_count, nib_count, geo_writes);
        if (err_count == 0) begin
            $display("tb_char_lcd_nibble_writer: done, clean");
        end else begin
            $display("tb_char_lcd_nibble_writer: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/lcd_nw_pkg.sv
src/lcd_nw_dec.sv
src/lcd_nw_ser.sv
src/char_lcd_nibble_writer.sv
verif/tb_char_lcd_nibble_writer.sv
